// ===== hdl/rvex_pkg.sv =====
// Shared types and constants of the RV32IM execute pipeline.
package rvex_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] EbreakWord = 32'h0010_0073;

  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;
  localparam logic [6:0] F7Mul  = 7'h01;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StIllegal = 2'd1;
  localparam logic [1:0] StEbreak  = 2'd2;

  localparam logic [2:0] MdMul    = 3'd0;
  localparam logic [2:0] MdMulh   = 3'd1;
  localparam logic [2:0] MdMulhsu = 3'd2;
  localparam logic [2:0] MdMulhu  = 3'd3;
  localparam logic [2:0] MdDiv    = 3'd4;
  localparam logic [2:0] MdDivu   = 3'd5;
  localparam logic [2:0] MdRem    = 3'd6;
  localparam logic [2:0] MdRemu   = 3'd7;

  // One word in flight through the pipeline.
  typedef struct packed {
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] mem_wdata;
    logic [1:0]  mem_size;
    logic        load_signed;
    logic [1:0]  status;
    logic        md;
    logic [2:0]  f3;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic        negq;
    logic        negr;
    logic        bzero;
    logic [31:0] pp_ll;
    logic [31:0] pp_lh;
    logic [31:0] pp_hl;
    logic [31:0] pp_hh;
    logic [63:0] prod;
  } pipe_t;

endpackage

// ===== hdl/riscv_integer_execute_unit.sv =====
// RV32IM execute unit: decode stage, 32-step divide pipeline, output register.
//
// Input channel: in_valid_i/in_ready_o carry one instruction word with its pc
// and both source operands. Output channel: out_valid_o/out_ready_i carry the
// register write, next pc, memory request and status of that word.
// Every word passes through the decode register, the 32 divide-step registers
// and the output register before its result shows on the outputs, so results
// leave in order.
// Throughput: one word per cycle. The restoring divider retires one quotient
// bit per stage; the 32x32 multiply is split into four 16x16 partial
// products, summed and sign-corrected in the first three divide stages.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated. While the output slot
// is empty or being drained, a new word is taken every cycle.
// Loads only issue the request; data extension happens downstream.
module riscv_integer_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] rs1_value_i,
  input  logic [31:0] rs2_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  rd_index_o,
  output logic        rd_write_o,
  output logic [31:0] rd_value_o,
  output logic [31:0] next_pc_o,
  output logic        mem_read_o,
  output logic        mem_write_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_wdata_o,
  output logic [1:0]  mem_size_o,
  output logic        load_signed_o,
  output logic [1:0]  status_o
);

  localparam int unsigned N = rvex_pkg::DivSteps;

  logic             adv;
  logic             valid_q [0:N];
  rvex_pkg::pipe_t  st_q    [0:N];
  rvex_pkg::pipe_t  st_d    [0:N];
  rvex_pkg::pipe_t  dec_d;
  logic             out_valid_q;
  rvex_pkg::pipe_t  out_q;
  rvex_pkg::pipe_t  out_d;

  // Global stall: everything moves when the output slot can be refilled.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- decode / ALU stage ----------------
  logic [31:0] ins, pc, a, b;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] immi, imms, immb, immj, immu;
  logic        wr, take, lts_b, lts_i;
  logic [4:0]  shi, shr;

  assign ins  = instruction_i;
  assign pc   = pc_i;
  assign a    = rs1_value_i;
  assign b    = rs2_value_i;
  assign op   = ins[6:0];
  assign rd   = ins[11:7];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign immi = {{20{ins[31]}}, ins[31:20]};
  assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign immu = {ins[31:12], 12'b0};
  assign shi  = ins[24:20];
  assign shr  = b[4:0];
  assign lts_b = $signed(a) < $signed(b);
  assign lts_i = $signed(a) < $signed(immi);

  always_comb begin
    rvex_pkg::pipe_t d;
    d = '0;
    wr = 1'b0;
    take = 1'b0;
    d.next_pc = pc + 32'd4;
    d.status  = rvex_pkg::StOk;
    d.f3 = f3;
    d.a  = a;
    d.b  = b;
    case (op)
      rvex_pkg::OpLui: begin
        wr = 1'b1; d.rd_value = immu;
      end
      rvex_pkg::OpAuipc: begin
        wr = 1'b1; d.rd_value = pc + immu;
      end
      rvex_pkg::OpJal: begin
        wr = 1'b1; d.rd_value = pc + 32'd4; d.next_pc = pc + immj;
      end
      rvex_pkg::OpJalr: begin
        if (f3 != 3'd0) begin
          d.status = rvex_pkg::StIllegal;
        end else begin
          wr = 1'b1; d.rd_value = pc + 32'd4;
          d.next_pc = (a + immi) & ~32'd1;
        end
      end
      rvex_pkg::OpBranch: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = lts_b;
          3'd5: take = !lts_b;
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: d.status = rvex_pkg::StIllegal;
        endcase
        if (take) d.next_pc = pc + immb;
      end
      rvex_pkg::OpLoad: begin
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
          d.status = rvex_pkg::StIllegal;
        end else begin
          d.mem_read = 1'b1; d.mem_address = a + immi;
          d.mem_size = f3[1:0]; d.load_signed = (f3 < 3'd2);
        end
      end
      rvex_pkg::OpStore: begin
        if (f3 > 3'd2) begin
          d.status = rvex_pkg::StIllegal;
        end else begin
          d.mem_write = 1'b1; d.mem_address = a + imms; d.mem_size = f3[1:0];
          case (f3)
            3'd0:    d.mem_wdata = {24'b0, b[7:0]};
            3'd1:    d.mem_wdata = {16'b0, b[15:0]};
            default: d.mem_wdata = b;
          endcase
        end
      end
      rvex_pkg::OpImm: begin
        wr = 1'b1;
        case (f3)
          3'd0: d.rd_value = a + immi;
          3'd2: d.rd_value = {31'b0, lts_i};
          3'd3: d.rd_value = {31'b0, a < immi};
          3'd4: d.rd_value = a ^ immi;
          3'd6: d.rd_value = a | immi;
          3'd7: d.rd_value = a & immi;
          3'd1: begin
            if (f7 != rvex_pkg::F7Base) d.status = rvex_pkg::StIllegal;
            else d.rd_value = a << shi;
          end
          default: begin
            if (f7 == rvex_pkg::F7Base) d.rd_value = a >> shi;
            else if (f7 == rvex_pkg::F7Alt) d.rd_value = 32'($signed(a) >>> shi);
            else d.status = rvex_pkg::StIllegal;
          end
        endcase
      end
      rvex_pkg::OpReg: begin
        wr = 1'b1;
        if (f7 == rvex_pkg::F7Mul) begin
          d.md = 1'b1;
          d.bzero = (b == 32'd0);
          if (f3 == rvex_pkg::MdDiv || f3 == rvex_pkg::MdRem) begin
            d.quo  = a[31] ? (32'd0 - a) : a;
            d.dvs  = b[31] ? (32'd0 - b) : b;
            d.negq = a[31] ^ b[31];
            d.negr = a[31];
          end else begin
            d.quo = a;
            d.dvs = b;
          end
        end else if (f7 == rvex_pkg::F7Base) begin
          case (f3)
            3'd0:    d.rd_value = a + b;
            3'd1:    d.rd_value = a << shr;
            3'd2:    d.rd_value = {31'b0, lts_b};
            3'd3:    d.rd_value = {31'b0, a < b};
            3'd4:    d.rd_value = a ^ b;
            3'd5:    d.rd_value = a >> shr;
            3'd6:    d.rd_value = a | b;
            default: d.rd_value = a & b;
          endcase
        end else if (f7 == rvex_pkg::F7Alt && f3 == 3'd0) begin
          d.rd_value = a - b;
        end else if (f7 == rvex_pkg::F7Alt && f3 == 3'd5) begin
          d.rd_value = 32'($signed(a) >>> shr);
        end else begin
          d.status = rvex_pkg::StIllegal;
        end
      end
      rvex_pkg::OpSystem: begin
        d.status = (ins == rvex_pkg::EbreakWord) ? rvex_pkg::StEbreak
                                                  : rvex_pkg::StIllegal;
      end
      default: d.status = rvex_pkg::StIllegal;
    endcase
    if (d.status != rvex_pkg::StOk) begin
      wr = 1'b0; d.md = 1'b0; d.mem_read = 1'b0; d.mem_write = 1'b0;
      d.load_signed = 1'b0; d.rd_value = '0; d.next_pc = pc;
      d.mem_address = '0; d.mem_wdata = '0; d.mem_size = '0;
    end
    d.rd_index = (wr || d.mem_read) ? rd : 5'd0;
    d.rd_write = wr && (rd != 5'd0);
    dec_d = d;
  end

  // ---------------- divide / multiply stages ----------------
  always_comb begin
    rvex_pkg::pipe_t s;
    logic [32:0] rsh;
    st_d[0] = dec_d;
    for (int k = 1; k <= N; k++) begin
      s   = st_q[k-1];
      rsh = {s.rem, s.quo[31]};
      if (rsh >= {1'b0, s.dvs}) begin
        s.rem = 32'(rsh - {1'b0, s.dvs});
        s.quo = {s.quo[30:0], 1'b1};
      end else begin
        s.rem = rsh[31:0];
        s.quo = {s.quo[30:0], 1'b0};
      end
      if (k == 1) begin
        s.pp_ll = {16'b0, s.a[15:0]}  * {16'b0, s.b[15:0]};
        s.pp_lh = {16'b0, s.a[15:0]}  * {16'b0, s.b[31:16]};
        s.pp_hl = {16'b0, s.a[31:16]} * {16'b0, s.b[15:0]};
        s.pp_hh = {16'b0, s.a[31:16]} * {16'b0, s.b[31:16]};
      end
      if (k == 2) begin
        s.prod = {s.pp_hh, s.pp_ll} + {16'b0, s.pp_lh, 16'b0}
               + {16'b0, s.pp_hl, 16'b0};
      end
      if (k == 3) begin
        // Signed high products from the unsigned one.
        if ((s.f3 == rvex_pkg::MdMulh || s.f3 == rvex_pkg::MdMulhsu) && s.a[31])
          s.prod[63:32] = s.prod[63:32] - s.b;
        if (s.f3 == rvex_pkg::MdMulh && s.b[31])
          s.prod[63:32] = s.prod[63:32] - s.a;
      end
      st_d[k] = s;
    end
  end

  // ---------------- result select ----------------
  always_comb begin
    out_d = st_q[N];
    if (st_q[N].md) begin
      case (st_q[N].f3)
        rvex_pkg::MdMul:    out_d.rd_value = st_q[N].prod[31:0];
        rvex_pkg::MdMulh,
        rvex_pkg::MdMulhsu,
        rvex_pkg::MdMulhu:  out_d.rd_value = st_q[N].prod[63:32];
        rvex_pkg::MdDiv,
        rvex_pkg::MdDivu: begin
          if (st_q[N].bzero) out_d.rd_value = '1;
          else if (st_q[N].negq) out_d.rd_value = 32'd0 - st_q[N].quo;
          else out_d.rd_value = st_q[N].quo;
        end
        default: begin
          out_d.rd_value = st_q[N].negr ? (32'd0 - st_q[N].rem) : st_q[N].rem;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= N; k++) valid_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int k = 1; k <= N; k++) valid_q[k] <= valid_q[k-1];
      out_valid_q <= valid_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= N; k++) st_q[k] <= st_d[k];
      out_q <= out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rd_index_o    = out_q.rd_index;
  assign rd_write_o    = out_q.rd_write;
  assign rd_value_o    = out_q.rd_value;
  assign next_pc_o     = out_q.next_pc;
  assign mem_read_o    = out_q.mem_read;
  assign mem_write_o   = out_q.mem_write;
  assign mem_address_o = out_q.mem_address;
  assign mem_wdata_o   = out_q.mem_wdata;
  assign mem_size_o    = out_q.mem_size;
  assign load_signed_o = out_q.load_signed;
  assign status_o      = out_q.status;

  // A trapped or illegal word never writes or touches memory.
  a_trap_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rvex_pkg::StOk
      |-> !rd_write_o && !mem_read_o && !mem_write_o)
    else $error("trap word has side effects");

  // x0 is never written.
  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rd_write_o |-> rd_index_o != 5'd0)
    else $error("write to x0");

  // Load and store are exclusive.
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(mem_read_o && mem_write_o))
    else $error("load and store together");

  // A stall holds the last stage's valid bit.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> valid_q[N] == $past(valid_q[N]))
    else $error("pipeline moved during stall");

endmodule

// ===== tb/sv/riscv_integer_execute_unit_tb.sv =====
// Testbench for the RV32IM execute unit: random and directed words, scoreboard check.
`timescale 1ns / 1ps

module riscv_integer_execute_unit_tb;

  typedef struct packed {
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] mem_wdata;
    logic [1:0]  mem_size;
    logic        load_signed;
    logic [1:0]  status;
  } exec_res_t;

  int unsigned err_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Signed less-than on raw words.
  function automatic bit lts(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] muldiv_value(logic [2:0] f3, logic [31:0] a,
                                               logic [31:0] b);
    logic [63:0] p;
    logic [31:0] q;
    logic [31:0] ma, mb;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (f3)
      rvex_pkg::MdMul:    return a * b;
      rvex_pkg::MdMulh: begin
        p = {{32{a[31]}}, a} * {{32{b[31]}}, b}; return p[63:32];
      end
      rvex_pkg::MdMulhsu: begin
        p = {{32{a[31]}}, a} * {32'd0, b}; return p[63:32];
      end
      rvex_pkg::MdMulhu: begin
        p = {32'd0, a} * {32'd0, b}; return p[63:32];
      end
      rvex_pkg::MdDiv: begin
        if (b == 0) return '1;
        if (a == 32'h8000_0000 && b == '1) return a;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
      end
      rvex_pkg::MdDivu:   return (b == 0) ? '1 : a / b;
      rvex_pkg::MdRem: begin
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == '1) return 0;
        q = ma % mb;
        return a[31] ? -q : q;
      end
      default:  return (b == 0) ? a : a % b;
    endcase
  endfunction

  function automatic exec_res_t execute_word(logic [31:0] ins, logic [31:0] pc,
                                             logic [31:0] a, logic [31:0] b);
    exec_res_t r;
    logic [6:0] op, f7;
    logic [2:0] f3;
    logic [31:0] immi, imms, immb, immj, immu, val;
    logic [1:0] st;
    bit wr, rdm, take;
    op = ins[6:0];
    f3 = ins[14:12];
    f7 = ins[31:25];
    immi = {{20{ins[31]}}, ins[31:20]};
    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    immu = {ins[31:12], 12'd0};
    r = '0;
    r.next_pc = pc + 4;
    val = 0; st = rvex_pkg::StOk; wr = 0; rdm = 0;
    case (op)
      rvex_pkg::OpLui:   begin wr = 1; val = immu; end
      rvex_pkg::OpAuipc: begin wr = 1; val = pc + immu; end
      rvex_pkg::OpJal:   begin wr = 1; val = pc + 4; r.next_pc = pc + immj; end
      rvex_pkg::OpJalr:
        if (f3 != 0) st = rvex_pkg::StIllegal;
        else begin wr = 1; val = pc + 4; r.next_pc = (a + immi) & ~32'd1; end
      rvex_pkg::OpBranch: begin
        take = 0;
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = lts(a, b);
          3'd5: take = !lts(a, b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: st = rvex_pkg::StIllegal;
        endcase
        if (st == rvex_pkg::StOk && take) r.next_pc = pc + immb;
      end
      rvex_pkg::OpLoad:
        if (f3 == 3 || f3 >= 6) st = rvex_pkg::StIllegal;
        else begin
          rdm = 1; r.mem_read = 1; r.mem_address = a + immi;
          r.mem_size = f3[1:0]; r.load_signed = f3 < 2;
        end
      rvex_pkg::OpStore:
        if (f3 > 2) st = rvex_pkg::StIllegal;
        else begin
          r.mem_write = 1; r.mem_address = a + imms; r.mem_size = f3[1:0];
          r.mem_wdata = (f3 == 0) ? (b & 32'hff) : (f3 == 1) ? (b & 32'hffff) : b;
        end
      rvex_pkg::OpImm: begin
        wr = 1;
        case (f3)
          3'd0: val = a + immi;
          3'd2: val = lts(a, immi);
          3'd3: val = a < immi;
          3'd4: val = a ^ immi;
          3'd6: val = a | immi;
          3'd7: val = a & immi;
          3'd1:
            if (f7 != rvex_pkg::F7Base) st = rvex_pkg::StIllegal;
            else val = a << immi[4:0];
          default:
            if (f7 == rvex_pkg::F7Base) val = a >> immi[4:0];
            else if (f7 == rvex_pkg::F7Alt) val = $signed(a) >>> immi[4:0];
            else st = rvex_pkg::StIllegal;
        endcase
      end
      rvex_pkg::OpReg: begin
        wr = 1;
        if (f7 == rvex_pkg::F7Mul) val = muldiv_value(f3, a, b);
        else if (f7 == rvex_pkg::F7Base)
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[4:0];
            3'd2: val = lts(a, b);
            3'd3: val = a < b;
            3'd4: val = a ^ b;
            3'd5: val = a >> b[4:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        else if (f7 == rvex_pkg::F7Alt && f3 == 0) val = a - b;
        else if (f7 == rvex_pkg::F7Alt && f3 == 5) val = $signed(a) >>> b[4:0];
        else st = rvex_pkg::StIllegal;
      end
      rvex_pkg::OpSystem:
        st = (ins == rvex_pkg::EbreakWord) ? rvex_pkg::StEbreak : rvex_pkg::StIllegal;
      default:  st = rvex_pkg::StIllegal;
    endcase
    if (st != rvex_pkg::StOk) begin
      r = '0;
      r.next_pc = pc;
      r.status = st;
      return r;
    end
    r.rd_index = (wr || rdm) ? ins[11:7] : 5'd0;
    r.rd_write = wr && ins[11:7] != 0;
    r.rd_value = wr ? val : 32'd0;
    return r;
  endfunction

  class exec_scoreboard;
    exec_res_t pending[$];

    function void note_word(logic [31:0] ins, logic [31:0] pc, logic [31:0] a,
                            logic [31:0] b);
      pending.push_back(execute_word(ins, pc, a, b));
    endfunction

    task check_result(exec_res_t got);
      exec_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.rd_index != e.rd_index)
        report_mismatch($sformatf("rd_index %0d exp %0d", got.rd_index, e.rd_index));
      if (got.rd_write != e.rd_write)
        report_mismatch($sformatf("rd_write %0d exp %0d", got.rd_write, e.rd_write));
      if (got.rd_value != e.rd_value)
        report_mismatch($sformatf("rd_value %h exp %h", got.rd_value, e.rd_value));
      if (got.next_pc != e.next_pc)
        report_mismatch($sformatf("next_pc %h exp %h", got.next_pc, e.next_pc));
      if (got.mem_read != e.mem_read)
        report_mismatch($sformatf("mem_read %0d exp %0d", got.mem_read, e.mem_read));
      if (got.mem_write != e.mem_write)
        report_mismatch($sformatf("mem_write %0d exp %0d", got.mem_write, e.mem_write));
      if (got.mem_address != e.mem_address)
        report_mismatch($sformatf("mem_address %h exp %h", got.mem_address,
                                  e.mem_address));
      if (got.mem_wdata != e.mem_wdata)
        report_mismatch($sformatf("mem_wdata %h exp %h", got.mem_wdata, e.mem_wdata));
      if (got.mem_size != e.mem_size)
        report_mismatch($sformatf("mem_size %0d exp %0d", got.mem_size, e.mem_size));
      if (got.load_signed != e.load_signed)
        report_mismatch($sformatf("load_signed %0d exp %0d", got.load_signed,
                                  e.load_signed));
      if (got.status != e.status)
        report_mismatch($sformatf("status %0d exp %0d", got.status, e.status));
    endtask
  endclass

  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [31:0] instruction = 0, pc = 0, rs1_value = 0, rs2_value = 0;
  wire exec_res_t got;
  exec_scoreboard sb = new();

  localparam int unsigned RandomWords = 1900;
  localparam int unsigned IdleLimit   = 5000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  riscv_integer_execute_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .instruction_i(instruction), .pc_i(pc),
    .rs1_value_i(rs1_value), .rs2_value_i(rs2_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .rd_index_o(got.rd_index), .rd_write_o(got.rd_write), .rd_value_o(got.rd_value),
    .next_pc_o(got.next_pc), .mem_read_o(got.mem_read), .mem_write_o(got.mem_write),
    .mem_address_o(got.mem_address), .mem_wdata_o(got.mem_wdata),
    .mem_size_o(got.mem_size), .load_signed_o(got.load_signed), .status_o(got.status)
  );

  // Sample both channels at the rising edge.
  bit in_fire, out_fire;
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    in_fire  = in_valid && in_ready && rst_n;
    out_fire = out_valid && out_ready && rst_n;
    if (in_fire) sb.note_word(instruction, pc, rs1_value, rs2_value);
    if (out_fire) sb.check_result(got);
    if (in_fire || out_fire || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stall pattern: the mode changes after a random span.
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  int burst_left = 0;

  // Hold one word until accepted; gaps come between bursts.
  task automatic send_word(input logic [31:0] ins, input logic [31:0] p,
                           input logic [31:0] a, input logic [31:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    instruction <= ins; pc <= p; rs1_value <= a; rs2_value <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return '1;
      2: return $urandom_range(0, 3);
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed RV32IM words with random fields; some pure noise.
  function automatic logic [31:0] rnd_instruction();
    logic [31:0] w;
    logic [6:0] ops[10];
    ops = '{rvex_pkg::OpLui, rvex_pkg::OpAuipc, rvex_pkg::OpJal, rvex_pkg::OpJalr,
            rvex_pkg::OpBranch, rvex_pkg::OpLoad, rvex_pkg::OpStore, rvex_pkg::OpImm,
            rvex_pkg::OpReg, rvex_pkg::OpSystem};
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return w;
      1: return rvex_pkg::EbreakWord;
      2, 3: begin
        w[6:0] = rvex_pkg::OpReg;
        w[31:25] = ($urandom_range(0, 2) == 0) ? rvex_pkg::F7Alt :
                   ($urandom_range(0, 1) ? rvex_pkg::F7Mul : rvex_pkg::F7Base);
      end
      4: begin
        w[6:0] = rvex_pkg::OpImm;
        if (w[13:12] == 2'b01 && $urandom_range(0, 3) != 0)
          w[31:25] = $urandom_range(0, 1) ? rvex_pkg::F7Alt : rvex_pkg::F7Base;
      end
      default: w[6:0] = ops[$urandom_range(0, 9)];
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] dir_words[$];
    int unsigned waited;
    dir_words = '{
      32'h1234_50b7, 32'hfffff_017, 32'h8000_006f, 32'h7ffff_0ef, 32'h0001_00e7,
      32'h0020_8463, 32'h0020_9063, 32'h0020_c063, 32'h0020_d063, 32'h0020_e063,
      32'h0020_f063, 32'h0020_a063, 32'h0000_4083, 32'h0000_3083, 32'h0000_2023,
      32'h0000_3023, 32'h0000_5013 | 32'h4000_0000, 32'h0200_1013, 32'h0220_40b3,
      32'h0220_60b3, 32'h4020_00b3, 32'h0220_10b3, rvex_pkg::EbreakWord, 32'h0000_0073,
      32'hffff_ffff
    };
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    foreach (dir_words[i])
      send_word(dir_words[i], (i % 2) ? 32'hffff_fffc : 32'h0,
                (i % 3 == 0) ? 32'h8000_0000 : ((i % 3 == 1) ? 32'hffff_ffff : 32'h0),
                (i % 2) ? 32'hffff_ffff : 32'h0);
    repeat (RandomWords) send_word(rnd_instruction(), $urandom, rnd_operand(), rnd_operand());
    in_valid <= 0;
    // Drain; the watchdog covers a hang here.
    while (sb.pending.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 40) begin
      @(posedge clk);
      waited++;
    end
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
